### hw/rtl/fssa_pkg.sv
package fssa_pkg;

  localparam int ADDR_BITS        = 16;
  localparam int LEN_BITS         = ADDR_BITS + 1;
  localparam int CNT_OUT_BITS     = 7;
  localparam int DEF_MAX_SEGMENTS = 64;

  localparam logic [LEN_BITS-1:0] POOL_LIMIT = LEN_BITS'(1) << ADDR_BITS;

  typedef enum logic [1:0] {
    CMD_ALLOC       = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_COUNT_SMALL = 2'd2,
    CMD_QUERY_USED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_t;

  localparam logic [1:0] CFG_FIT_STRATEGY = 2'd0;
  localparam logic [1:0] CFG_POOL_BYTES   = 2'd1;

  typedef struct packed {
    cmd_t                  cmd;
    logic [LEN_BITS-1:0]   req_size;
    logic [ADDR_BITS-1:0]  address;
  } in_t;

  typedef struct packed {
    logic                    ok;
    logic [ADDR_BITS-1:0]    result_addr;
    logic [CNT_OUT_BITS-1:0] answer;
    logic [CNT_OUT_BITS-1:0] hole_count;
    logic [LEN_BITS-1:0]     used_bytes;
    logic [LEN_BITS-1:0]     free_bytes;
    logic [LEN_BITS-1:0]     largest_hole;
  } out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [LEN_BITS-1:0]  len;
    logic                 used;
  } seg_t;

endpackage

### hw/rtl/fit_strategy_segment_allocator_top.sv
// Segment allocator: address-ordered segment table in one synchronous RAM.
// Each command runs a table scan, a decide step, an entry shift (moving entries to open or
// close a slot), fix-up writes, a statistics scan and an output load, in that order.
// Reset (synchronous, rst high): one free segment covering 65536 bytes,
// best fit, rover at 0. No clearing pass: only entry 0 is written at reset.
module fit_strategy_segment_allocator_top
  import fssa_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [LEN_BITS-1:0] cfg_data
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // one-hot sequencer
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_SHIFT  = 7'b0001000,
    ST_WRITE  = 7'b0010000,
    ST_STATS  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // configuration and table control
  fit_t                 fit;
  logic [CNT_W-1:0]     count;
  logic [ADDR_BITS-1:0] rover;
  in_t                  cur;

  // segment RAM
  seg_t             mem [MAX_SEGMENTS];
  seg_t             rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  seg_t             mem_wd;
  logic [IDX_W-1:0] mem_ra;

  // scan read pipeline
  logic [CNT_W-1:0] scan_ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             scan_issue;
  logic             scan_last;

  // allocate candidates: pk is the rule's pick, alt is next fit's pick past the rover
  logic             pk_v, alt_v;
  logic [IDX_W-1:0] pk_idx, alt_idx;
  seg_t             pk_ent, alt_ent;
  logic [CNT_W-1:0] acc_cnt;
  logic             q_found;

  // release match and its neighbors
  logic             m_v, m_prev_v, m_next_v;
  logic [IDX_W-1:0] m_idx;
  seg_t             m_ent, m_prev, m_next, prev_ent;

  // entry shift
  logic             sh_open;
  logic [CNT_W-1:0] sh_left;
  logic [IDX_W-1:0] sh_src;
  logic [IDX_W-1:0] sh_d;
  logic             sh_wv;
  logic [IDX_W-1:0] sh_wa;

  // fix-up writes
  logic             w0_v, w1_v, wphase;
  logic [IDX_W-1:0] w0_a, w1_a;
  seg_t             w0_d, w1_d;

  // result and statistics
  logic                 r_ok;
  logic [ADDR_BITS-1:0] r_addr;
  logic [CNT_W-1:0]     st_holes;
  logic [LEN_BITS-1:0]  st_used, st_free, st_large;

  logic                in_xfer, cfg_xfer, out_xfer;
  logic [LEN_BITS-1:0] pool_sat;
  seg_t                scan_e;
  logic                fits;

  // allocate decision
  logic             sel_v;
  logic [IDX_W-1:0] sel_idx;
  seg_t             sel_ent;
  logic             split;
  logic             alloc_ok;
  logic [CNT_W-1:0] cnt_after;
  logic             left_free, right_free;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_xfer  = out_valid && !out_stall;
  assign pool_sat  = (cfg_data > POOL_LIMIT) ? POOL_LIMIT : cfg_data;

  assign scan_e     = rdata;
  assign scan_issue = ((state == ST_SCAN) || (state == ST_STATS)) && (scan_ptr < count);
  assign scan_last  = rd_vld && (CNT_W'(rd_idx) == count - CNT_ONE);
  assign fits       = !scan_e.used && (scan_e.len >= cur.req_size);

  // next fit takes the first hole past the rover, else wraps to the first hole
  always_comb begin
    if (fit == FIT_NEXT && alt_v) begin
      sel_v   = 1'b1;
      sel_idx = alt_idx;
      sel_ent = alt_ent;
    end else begin
      sel_v   = pk_v;
      sel_idx = pk_idx;
      sel_ent = pk_ent;
    end
  end

  assign split      = sel_ent.len > cur.req_size;
  assign alloc_ok   = (cur.req_size != '0) && sel_v && !(split && count >= CNT_MAX);
  assign cnt_after  = split ? count + CNT_ONE : count;
  assign left_free  = m_prev_v && !m_prev.used;
  assign right_free = m_next_v && !m_next.used;

  // RAM port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = scan_ptr[IDX_W-1:0];
    if (rst) begin
      mem_we = 1'b1;
      mem_wd = '{base: '0, len: POOL_LIMIT, used: 1'b0};
    end else if (cfg_xfer && cfg_index == CFG_POOL_BYTES) begin
      mem_we = 1'b1;
      mem_wd = '{base: '0, len: pool_sat, used: 1'b0};
    end else begin
      unique case (state)
        ST_SHIFT: begin
          mem_ra = sh_src;
          if (sh_wv) begin
            mem_we = 1'b1;
            mem_wa = sh_wa;
            mem_wd = rdata;
          end
        end
        ST_WRITE: begin
          if (!wphase && w0_v) begin
            mem_we = 1'b1;
            mem_wa = w0_a;
            mem_wd = w0_d;
          end else if (wphase && w1_v) begin
            mem_we = 1'b1;
            mem_wa = w1_a;
            mem_wd = w1_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fit       <= FIT_BEST;
      count     <= CNT_ONE;
      rover     <= '0;
      rd_vld    <= 1'b0;
      sh_wv     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      rd_idx <= scan_ptr[IDX_W-1:0];
      if (scan_issue) begin
        scan_ptr <= scan_ptr + CNT_ONE;
      end
      // in ST_DONE the result load below decides out_valid
      if (out_xfer && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cfg_xfer) begin
            if (cfg_index == CFG_FIT_STRATEGY) begin
              fit <= fit_t'(cfg_data[1:0]);
            end else if (cfg_index == CFG_POOL_BYTES) begin
              count <= CNT_ONE;
              rover <= '0;
            end
          end
          if (in_xfer) begin
            cur      <= in_data;
            scan_ptr <= '0;
            pk_v     <= 1'b0;
            alt_v    <= 1'b0;
            acc_cnt  <= '0;
            q_found  <= 1'b0;
            m_v      <= 1'b0;
            m_next_v <= 1'b0;
            r_ok     <= 1'b0;
            r_addr   <= '0;
            w0_v     <= 1'b0;
            w1_v     <= 1'b0;
            sh_left  <= '0;
            state    <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (rd_vld) begin
            prev_ent <= scan_e;
            case (cur.cmd)
              CMD_ALLOC: begin
                case (fit)
                  FIT_BEST: begin
                    if (fits && (!pk_v || scan_e.len < pk_ent.len)) begin
                      pk_v <= 1'b1; pk_idx <= rd_idx; pk_ent <= scan_e;
                    end
                  end
                  FIT_WORST: begin
                    if (fits && (!pk_v || scan_e.len > pk_ent.len)) begin
                      pk_v <= 1'b1; pk_idx <= rd_idx; pk_ent <= scan_e;
                    end
                  end
                  default: begin
                    if (fits && !pk_v) begin
                      pk_v <= 1'b1; pk_idx <= rd_idx; pk_ent <= scan_e;
                    end
                  end
                endcase
                // segment ends past the rover: at or after the rover's segment
                if (fits && !alt_v
                    && (LEN_BITS'(scan_e.base) + scan_e.len > LEN_BITS'(rover))) begin
                  alt_v <= 1'b1; alt_idx <= rd_idx; alt_ent <= scan_e;
                end
              end
              CMD_RELEASE: begin
                if (!m_v && scan_e.used && scan_e.base == cur.address) begin
                  m_v      <= 1'b1;
                  m_idx    <= rd_idx;
                  m_ent    <= scan_e;
                  m_prev   <= prev_ent;
                  m_prev_v <= (rd_idx != '0);
                end
                if (m_v && !m_next_v && rd_idx == m_idx + IDX_W'(1)) begin
                  m_next   <= scan_e;
                  m_next_v <= 1'b1;
                end
              end
              CMD_COUNT_SMALL: begin
                if (!scan_e.used && scan_e.len <= cur.req_size) begin
                  acc_cnt <= acc_cnt + CNT_ONE;
                end
              end
              default: begin
                if (!q_found && scan_e.base == cur.address) begin
                  q_found <= 1'b1;
                  acc_cnt <= CNT_W'(scan_e.used);
                end
              end
            endcase
          end
          if (scan_last) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          state <= ST_SHIFT;
          sh_wv <= 1'b0;
          if (cur.cmd == CMD_ALLOC && alloc_ok) begin
            r_ok   <= 1'b1;
            r_addr <= sel_ent.base;
            w0_v   <= 1'b1;
            w0_a   <= sel_idx;
            w0_d   <= '{base: sel_ent.base, len: cur.req_size, used: 1'b1};
            if (split) begin
              // open a slot above the pick for the remainder
              w1_v    <= 1'b1;
              w1_a    <= sel_idx + IDX_W'(1);
              w1_d    <= '{base: ADDR_BITS'(LEN_BITS'(sel_ent.base) + cur.req_size),
                           len: sel_ent.len - cur.req_size, used: 1'b0};
              sh_open <= 1'b1;
              sh_left <= count - CNT_ONE - CNT_W'(sel_idx);
              sh_src  <= IDX_W'(count - CNT_ONE);
              count   <= count + CNT_ONE;
            end
            if (fit == FIT_NEXT) begin
              // segments are contiguous: the next base is base + request
              rover <= (CNT_W'(sel_idx) + CNT_ONE < cnt_after)
                       ? ADDR_BITS'(LEN_BITS'(sel_ent.base) + cur.req_size) : '0;
            end
          end else if (cur.cmd == CMD_RELEASE && m_v) begin
            r_ok    <= 1'b1;
            w0_v    <= 1'b1;
            sh_open <= 1'b0;
            if (left_free) begin
              w0_a   <= m_idx - IDX_W'(1);
              sh_src <= m_idx + (right_free ? IDX_W'(2) : IDX_W'(1));
              sh_d   <= right_free ? IDX_W'(2) : IDX_W'(1);
              if (right_free) begin
                w0_d    <= '{base: m_prev.base,
                             len: m_prev.len + m_ent.len + m_next.len, used: 1'b0};
                sh_left <= count - CNT_W'(m_idx) - CNT_W'(2);
                count   <= count - CNT_W'(2);
              end else begin
                w0_d    <= '{base: m_prev.base, len: m_prev.len + m_ent.len, used: 1'b0};
                sh_left <= count - CNT_W'(m_idx) - CNT_ONE;
                count   <= count - CNT_ONE;
              end
            end else begin
              w0_a <= m_idx;
              if (right_free) begin
                w0_d    <= '{base: m_ent.base, len: m_ent.len + m_next.len, used: 1'b0};
                sh_src  <= m_idx + IDX_W'(2);
                sh_d    <= IDX_W'(1);
                sh_left <= count - CNT_W'(m_idx) - CNT_W'(2);
                count   <= count - CNT_ONE;
              end else begin
                w0_d <= '{base: m_ent.base, len: m_ent.len, used: 1'b0};
              end
            end
          end
        end

        ST_SHIFT: begin
          if (sh_left != '0) begin
            sh_wv   <= 1'b1;
            sh_wa   <= sh_open ? sh_src + IDX_W'(1) : sh_src - sh_d;
            sh_src  <= sh_open ? sh_src - IDX_W'(1) : sh_src + IDX_W'(1);
            sh_left <= sh_left - CNT_ONE;
          end else begin
            sh_wv <= 1'b0;
            if (!sh_wv) begin
              wphase <= 1'b0;
              state  <= ST_WRITE;
            end
          end
        end

        ST_WRITE: begin
          wphase <= 1'b1;
          if (wphase) begin
            scan_ptr <= '0;
            st_holes <= '0;
            st_used  <= '0;
            st_free  <= '0;
            st_large <= '0;
            state    <= ST_STATS;
          end
        end

        ST_STATS: begin
          if (rd_vld) begin
            if (scan_e.used) begin
              st_used <= st_used + scan_e.len;
            end else begin
              st_holes <= st_holes + CNT_ONE;
              st_free  <= st_free + scan_e.len;
              if (scan_e.len > st_large) begin
                st_large <= scan_e.len;
              end
            end
          end
          if (scan_last) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          // result register parts the two sides: wait only for a held result
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_data.ok           <= r_ok;
            out_data.result_addr  <= r_addr;
            out_data.answer       <= CNT_OUT_BITS'(acc_cnt);
            out_data.hole_count   <= CNT_OUT_BITS'(st_holes);
            out_data.used_bytes   <= st_used;
            out_data.free_bytes   <= st_free;
            out_data.largest_hole <= st_large;
            state                 <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
